[hw/rtl/scdp_pkg.sv]
// Shared types for the surface current density pipeline.
// Used by scdp_sqrt_cell, scdp_div_cell and the top level; no dependencies.
`timescale 1ns / 1ps
package scdp_pkg;

  localparam int unsigned SqrtCells = 32;
  localparam int unsigned DivCells  = 65;
  localparam int unsigned NumW      = 65;
  localparam int unsigned RootW     = 32;
  localparam int unsigned SqRemW    = 36;
  localparam int unsigned DivRemW   = 33;
  localparam int unsigned OutW      = 48;
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [CfgIdxW-1:0] RegToroidal = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPoloidal = 8'd1;

  // one beat travelling through the square-root chain
  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [63:0]               v;
    logic [SqRemW-1:0]         rem;
    logic [RootW-1:0]          root;
    logic [2:0]                neg;
    logic [2:0][NumW-1:0]      num;
  } sqrt_beat_t;

  // one beat travelling through the divider chain
  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [RootW-1:0]          den;
    logic [2:0]                neg;
    logic [2:0][NumW-1:0]      num;
    logic [2:0][DivRemW-1:0]   rem;
    logic [2:0][NumW-1:0]      quo;
  } div_beat_t;

endpackage

[hw/rtl/scdp_sqrt_cell.sv]
// One digit of the integer square root: two radicand bits in, one root bit out.
// Depends on scdp_pkg.
`timescale 1ns / 1ps
module scdp_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scdp_pkg::sqrt_beat_t beat_i,
  output scdp_pkg::sqrt_beat_t beat_o
);

  logic [scdp_pkg::SqRemW-1:0] r2, trial;
  logic                        valid_q;
  scdp_pkg::sqrt_beat_t beat_d, beat_q;

  always_comb begin
    beat_d = beat_i;
    r2     = {beat_i.rem[scdp_pkg::SqRemW-3:0], beat_i.v[63:62]};
    trial  = {2'b00, beat_i.root, 2'b01};
    beat_d.v = {beat_i.v[61:0], 2'b00};
    if (r2 >= trial) begin
      beat_d.rem  = r2 - trial;
      beat_d.root = {beat_i.root[scdp_pkg::RootW-2:0], 1'b1};
    end else begin
      beat_d.rem  = r2;
      beat_d.root = {beat_i.root[scdp_pkg::RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_d.valid;
    end
  end

  // payload flops carry no reset; the valid bit comes from valid_q
  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

[hw/rtl/scdp_div_cell.sv]
// One quotient bit of three restoring divisions sharing one divisor.
// Depends on scdp_pkg.
`timescale 1ns / 1ps
module scdp_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scdp_pkg::div_beat_t beat_i,
  output scdp_pkg::div_beat_t beat_o
);

  logic [scdp_pkg::DivRemW-1:0] r2 [3];
  logic                         valid_q;
  scdp_pkg::div_beat_t beat_d, beat_q;

  always_comb begin
    beat_d = beat_i;
    for (int c = 0; c < 3; c++) begin
      r2[c] = {beat_i.rem[c][scdp_pkg::DivRemW-2:0], beat_i.num[c][scdp_pkg::NumW-1]};
      beat_d.num[c] = {beat_i.num[c][scdp_pkg::NumW-2:0], 1'b0};
      if (r2[c] >= {1'b0, beat_i.den}) begin
        beat_d.rem[c] = r2[c] - {1'b0, beat_i.den};
        beat_d.quo[c] = {beat_i.quo[c][scdp_pkg::NumW-2:0], 1'b1};
      end else begin
        beat_d.rem[c] = r2[c];
        beat_d.quo[c] = {beat_i.quo[c][scdp_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_d.valid;
    end
  end

  // payload flops carry no reset; the valid bit comes from valid_q
  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

[hw/rtl/surface_current_density_point_top.sv]
// Top level of the surface current density pipeline.
// Depends on scdp_pkg, scdp_sqrt_cell and scdp_div_cell.
//
// Usage:
//   Input channel: drive the point fields and pulse start; a beat is taken
//   at every edge where start is high and busy is low. busy stays low,
//   so one point may enter on every cycle.
//   Result channel: done_o is high for one cycle with cur_x_o/cur_y_o/cur_z_o
//   and zero_norm_o; the receiver cannot stall, results must be taken then.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 toroidal,
//   1 poloidal current) and cfg_data_i; other indexes are dropped. Write only
//   while the pipeline is empty.
// Path from the accepting edge to the result: the registered sums, products
//   and squares, 32 square-root cells (one root bit each), 65 divider cells
//   (one quotient bit each) and the output register. Throughput: one point
//   per cycle.
// Reset clears all stage valid bits and both net current registers.
`timescale 1ns / 1ps
module surface_current_density_point_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               tan1_x_i,
  input  logic signed [31:0]               tan1_y_i,
  input  logic signed [31:0]               tan1_z_i,
  input  logic signed [31:0]               tan2_x_i,
  input  logic signed [31:0]               tan2_y_i,
  input  logic signed [31:0]               tan2_z_i,
  input  logic signed [31:0]               norm_x_i,
  input  logic signed [31:0]               norm_y_i,
  input  logic signed [31:0]               norm_z_i,
  input  logic signed [31:0]               pot_deriv1_i,
  input  logic signed [31:0]               pot_deriv2_i,
  input  logic                             add_net_i,
  output logic                             done_o,
  output logic signed [47:0]               cur_x_o,
  output logic signed [47:0]               cur_y_o,
  output logic signed [47:0]               cur_z_o,
  output logic                             zero_norm_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [scdp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic signed [31:0]               cfg_data_i
);

  localparam logic [64:0] PosMax = 65'h7FFF_FFFF_FFFF;
  localparam logic [64:0] NegMax = 65'h8000_0000_0000;

  logic signed [31:0] tor_q, pol_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tor_q <= '0;
      pol_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == scdp_pkg::RegToroidal) tor_q <= cfg_data_i;
      if (cfg_index_i == scdp_pkg::RegPoloidal) pol_q <= cfg_data_i;
    end
  end

  // stage 1: net current sums, normal magnitudes
  logic               v1_q, v2_q, v3_q;
  logic signed [32:0] a1_q, b1_q;
  logic signed [31:0] t1_q [3];
  logic signed [31:0] t2_q [3];
  logic [31:0]        nm_q [3];
  logic signed [31:0] nin [3];

  assign nin[0] = norm_x_i;
  assign nin[1] = norm_y_i;
  assign nin[2] = norm_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= 33'(pot_deriv2_i) + (add_net_i ? 33'(tor_q) : 33'sd0);
    b1_q <= 33'(pot_deriv1_i) + (add_net_i ? 33'(pol_q) : 33'sd0);
    t1_q[0] <= tan1_x_i;
    t1_q[1] <= tan1_y_i;
    t1_q[2] <= tan1_z_i;
    t2_q[0] <= tan2_x_i;
    t2_q[1] <= tan2_y_i;
    t2_q[2] <= tan2_z_i;
    for (int c = 0; c < 3; c++) begin
      nm_q[c] <= nin[c][31] ? 32'(-$signed({nin[c][31], nin[c]})) : nin[c];
    end
  end

  // stage 2: products and squares
  logic signed [64:0] p1_q [3];
  logic signed [64:0] p2_q [3];
  logic [63:0]        sqr_q [3];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      p1_q[c]  <= t1_q[c] * a1_q;
      p2_q[c]  <= t2_q[c] * b1_q;
      sqr_q[c] <= nm_q[c] * nm_q[c];
    end
  end

  // stage 3: numerators and sum of squares (mod 2^64)
  logic [63:0]            sq_q;
  logic [2:0]             neg3_q;
  logic [2:0][64:0]       mag3_q;
  logic signed [65:0]     diff [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = {p2_q[c][64], p2_q[c]} - {p1_q[c][64], p1_q[c]};
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sqr_q[0] + sqr_q[1] + sqr_q[2];
    for (int c = 0; c < 3; c++) begin
      neg3_q[c] <= diff[c][65];
      mag3_q[c] <= diff[c][65] ? 65'(-diff[c]) : diff[c][64:0];
    end
  end

  // square-root chain
  scdp_pkg::sqrt_beat_t sb [scdp_pkg::SqrtCells+1];

  always_comb begin
    sb[0].valid = v3_q;
    sb[0].zero  = (sq_q == '0);
    sb[0].v     = sq_q;
    sb[0].rem   = '0;
    sb[0].root  = '0;
    sb[0].neg   = neg3_q;
    sb[0].num   = mag3_q;
  end

  for (genvar k = 0; k < scdp_pkg::SqrtCells; k++) begin : g_sqrt
    scdp_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (sb[k]),
      .beat_o (sb[k+1])
    );
  end

  // divider chain
  scdp_pkg::div_beat_t db [scdp_pkg::DivCells+1];

  always_comb begin
    db[0].valid = sb[scdp_pkg::SqrtCells].valid;
    db[0].zero  = sb[scdp_pkg::SqrtCells].zero;
    db[0].den   = sb[scdp_pkg::SqrtCells].root;
    db[0].neg   = sb[scdp_pkg::SqrtCells].neg;
    db[0].num   = sb[scdp_pkg::SqrtCells].num;
    db[0].rem   = '0;
    db[0].quo   = '0;
  end

  for (genvar k = 0; k < scdp_pkg::DivCells; k++) begin : g_div
    scdp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (db[k]),
      .beat_o (db[k+1])
    );
  end

  // saturation and output register
  scdp_pkg::div_beat_t last;
  logic [47:0]         sat [3];
  logic                done_q, zero_q;
  logic [47:0]         cur_q [3];
  logic [31:0]         den_q;

  assign last = db[scdp_pkg::DivCells];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (last.zero) begin
        sat[c] = '0;
      end else if (last.neg[c]) begin
        sat[c] = (last.quo[c] > NegMax) ? 48'h8000_0000_0000
                                         : 48'(-last.quo[c][47:0]);
      end else begin
        sat[c] = (last.quo[c] > PosMax) ? 48'h7FFF_FFFF_FFFF : last.quo[c][47:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= last.zero;
    den_q  <= last.den;
    for (int c = 0; c < 3; c++) begin
      cur_q[c] <= sat[c];
    end
  end

  assign done_o      = done_q;
  assign zero_norm_o = zero_q;
  assign cur_x_o     = cur_q[0];
  assign cur_y_o     = cur_q[1];
  assign cur_z_o     = cur_q[2];

  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_norm_o |-> cur_x_o == '0 && cur_y_o == '0 && cur_z_o == '0)
    else $error("zero norm result carries nonzero current");

  a_nonzero_has_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !zero_norm_o |-> den_q != '0)
    else $error("nonzero norm produced a zero root");

  a_div_follows_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    db[1].valid |-> $past(sb[scdp_pkg::SqrtCells].valid))
    else $error("divider beat without square-root beat");

endmodule
